[rtl/core/vn_pkg.sv]
// ============================================================================
// vn_pkg
// Shared widths, constants and types for the 3-D vector normaliser.
// ============================================================================
package vn_pkg;

    // component width, signed Q16.16 carried in the low CW bits
    localparam int CW      = 32;
    // fraction bits of the input components
    localparam int FRAC    = 16;
    // squared length width: three squares of CW-bit magnitudes
    localparam int SW      = 2 * CW + 2;
    // extra fraction bits appended to S before the square root (32 + 32 fraction)
    localparam int SQ_PAD  = 32;
    // internal length width (32 fraction bits): sqrt of S * 2^32
    localparam int LW      = (SW + SQ_PAD) / 2;
    // square root remainder width
    localparam int RW      = LW + 3;
    // quotient bits below the overflow point, and its Q1.30 output
    localparam int QW      = 31;
    localparam int UNIT_W  = 32;
    localparam int UNIT_FRAC = 30;
    localparam int MAG_W   = 33;
    // numerator is mag * 2^46, its part above the quotient bits is mag * 2^15
    localparam int PRE_SH  = UNIT_FRAC + SQ_PAD - FRAC - QW;
    // divider remainder width
    localparam int DW      = LW + 1;
    // width of the band bounds around one
    localparam int BW      = 34;
    localparam int TOL_W   = 32;

    localparam logic [BW-1:0]     ONE_S        = BW'(64'h1_0000_0000);
    localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(4295);
    localparam logic [LW-1:0]     NEAR_BASE    = LW'(64'h8000_0000);
    localparam logic [QW-1:0]     UNIT_ONE     = QW'(64'h4000_0000);

    // pipeline latencies
    localparam int FRONT_LAT = 4;
    localparam int DIV_LAT   = QW + 2;
    localparam int TOTAL_LAT = FRONT_LAT + LW + 1 + DIV_LAT + 1;

    // one vector after the front end
    typedef struct packed {
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
        logic               near;
        logic [LW-1:0]      near_len;
        logic [SW-1:0]      s;
    } t_item;

endpackage

[rtl/core/vector3_normalizer.sv]
// Pipeline: front end, square root, length select, divide, then output register;
//   one root bit and one quotient bit per pipeline stage.
// Throughput: one vector per cycle; the whole pipeline advances together and
//   holds only while a finished result waits under stall.
// Reset: synchronous active-low i_rst_n clears all valid flags and loads the
//   near-one tolerance with 4295.
// ============================================================================
// vector3_normalizer
// Scales a signed Q16.16 3-D vector to unit length in Q1.30, with its length.
// ============================================================================
module vector3_normalizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [vn_pkg::TOL_W-1:0]         i_cfg_wr_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [vn_pkg::CW-1:0]     i_vec_x,
    input  logic signed [vn_pkg::CW-1:0]     i_vec_y,
    input  logic signed [vn_pkg::CW-1:0]     i_vec_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [vn_pkg::UNIT_W-1:0] o_unit_x,
    output logic signed [vn_pkg::UNIT_W-1:0] o_unit_y,
    output logic signed [vn_pkg::UNIT_W-1:0] o_unit_z,
    output logic [vn_pkg::MAG_W-1:0]         o_magnitude,
    output logic                             o_was_zero
);
    import vn_pkg::*;

    localparam int XW = LW + MAG_W + FRAC;

    logic                     en;
    logic [BW-1:0]            r_band_lo;
    logic [BW-1:0]            r_band_hi;
    logic [TOTAL_LAT-1:0]     r_vld;
    t_item                    front_item;
    t_item                    sq_item;
    logic [LW-1:0]            sq_root;
    t_item                    r_sel_item;
    logic [LW-1:0]            r_sel_len;
    logic [XW-1:0]            len_x;
    logic [MAG_W-1:0]         sel_mag;
    logic [MAG_W-1:0]         r_dl_mag  [DIV_LAT];
    logic                     r_dl_zero [DIV_LAT];
    logic [2:0][UNIT_W-1:0]   lane_unit;
    logic [2:0][UNIT_W-1:0]   r_out_unit;
    logic [MAG_W-1:0]         r_out_mag;
    logic                     r_out_zero;

    // whole pipeline moves unless a held result is stalled
    assign en      = ~(r_vld[TOTAL_LAT-1] & i_stall);
    assign o_stall = ~en;

    // tolerance register kept as the two band bounds around one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_lo <= ONE_S - BW'(TOL_RESET);
            r_band_hi <= ONE_S + BW'(TOL_RESET);
        end else if (i_cfg_wr_en) begin
            r_band_lo <= ONE_S - BW'(i_cfg_wr_data);
            r_band_hi <= ONE_S + BW'(i_cfg_wr_data);
        end
    end

    // valid flags following the data through every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_valid};
        end
    end

    vn_front u_front (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_vec_x   (i_vec_x),
        .i_vec_y   (i_vec_y),
        .i_vec_z   (i_vec_z),
        .i_band_lo (r_band_lo),
        .i_band_hi (r_band_hi),
        .o_item    (front_item)
    );

    vn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (front_item),
        .o_item (sq_item),
        .o_root (sq_root)
    );

    // pick the length: near-one estimate or square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel_item <= sq_item;
            r_sel_len  <= sq_item.near ? sq_item.near_len : sq_root;
        end
    end

    // length reported as Q17.16, saturated
    assign len_x = XW'(r_sel_len);
    assign sel_mag = (|len_x[XW-1:FRAC+MAG_W]) ? {MAG_W{1'b1}}
                                               : len_x[FRAC+MAG_W-1:FRAC];

    // one divider lane per component
    for (genvar i = 0; i < 3; i++) begin : g_lane
        vn_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_mag  (r_sel_item.mag[i]),
            .i_neg  (r_sel_item.neg[i]),
            .i_len  (r_sel_len),
            .o_unit (lane_unit[i])
        );
    end

    // magnitude and zero flag delayed alongside the lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_mag[0]  <= sel_mag;
            r_dl_zero[0] <= r_sel_item.zero;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl_mag[k]  <= r_dl_mag[k-1];
                r_dl_zero[k] <= r_dl_zero[k-1];
            end
        end
    end

    // merge lanes into the output register, zero vector forces all zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_zero <= r_dl_zero[DIV_LAT-1];
            r_out_mag  <= r_dl_zero[DIV_LAT-1] ? '0 : r_dl_mag[DIV_LAT-1];
            for (int i = 0; i < 3; i++) begin
                r_out_unit[i] <= r_dl_zero[DIV_LAT-1] ? '0 : lane_unit[i];
            end
        end
    end

    assign o_valid     = r_vld[TOTAL_LAT-1];
    assign o_unit_x    = r_out_unit[0];
    assign o_unit_y    = r_out_unit[1];
    assign o_unit_z    = r_out_unit[2];
    assign o_magnitude = r_out_mag;
    assign o_was_zero  = r_out_zero;

    // zero vector gives all-zero components and length
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_zero) |->
            (o_magnitude == '0 && o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0))
        else $error("zero vector with nonzero result");

    // components never exceed one in magnitude
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_x <= 32'sd1073741824 && o_unit_x >= -32'sd1073741824
                  && o_unit_y <= 32'sd1073741824 && o_unit_y >= -32'sd1073741824
                  && o_unit_z <= 32'sd1073741824 && o_unit_z >= -32'sd1073741824))
        else $error("normalised component out of range");

    // a frozen pipeline keeps its valid flags
    a_hold_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid flags moved during stall");

endmodule

[rtl/core/vn_front.sv]
// ============================================================================
// vn_front
// Magnitudes, squares, exact squared length and the zero and near-one tests.
// ============================================================================
module vn_front (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [vn_pkg::CW-1:0]  i_vec_x,
    input  logic signed [vn_pkg::CW-1:0]  i_vec_y,
    input  logic signed [vn_pkg::CW-1:0]  i_vec_z,
    input  logic [vn_pkg::BW-1:0]         i_band_lo,
    input  logic [vn_pkg::BW-1:0]         i_band_hi,
    output vn_pkg::t_item                 o_item
);
    import vn_pkg::*;

    logic [2:0][CW-1:0]   raw;
    logic [2:0][CW-1:0]   r_mag_a;
    logic [2:0]           r_neg_a;
    logic [2:0][CW-1:0]   r_mag_b;
    logic [2:0]           r_neg_b;
    logic [2:0][2*CW-1:0] r_sq_b;
    logic [2:0][CW-1:0]   r_mag_c;
    logic [2:0]           r_neg_c;
    logic [SW-1:0]        r_s_c;
    t_item                r_item;
    logic [SW-1:0]        n_s;

    assign raw[0] = i_vec_x;
    assign raw[1] = i_vec_y;
    assign raw[2] = i_vec_z;

    // sign and magnitude, most negative value keeps its pattern
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg_a[i] <= raw[i][CW-1];
                r_mag_a[i] <= raw[i][CW-1] ? (~raw[i] + CW'(1)) : raw[i];
            end
        end
    end

    // one multiplier per component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_b <= r_mag_a;
            r_neg_b <= r_neg_a;
            for (int i = 0; i < 3; i++) begin
                r_sq_b[i] <= (2*CW)'(r_mag_a[i]) * (2*CW)'(r_mag_a[i]);
            end
        end
    end

    // sum of squares
    assign n_s = SW'(r_sq_b[0]) + SW'(r_sq_b[1]) + SW'(r_sq_b[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_c <= r_mag_b;
            r_neg_c <= r_neg_b;
            r_s_c   <= n_s;
        end
    end

    // zero and near-one tests
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.mag      <= r_mag_c;
            r_item.neg      <= r_neg_c;
            r_item.s        <= r_s_c;
            r_item.zero     <= (r_s_c == '0);
            r_item.near     <= (r_s_c >= SW'(i_band_lo)) && (r_s_c <= SW'(i_band_hi));
            r_item.near_len <= NEAR_BASE + LW'(r_s_c[SW-1:1]);
        end
    end

    assign o_item = r_item;

endmodule

[rtl/core/vn_sqrt.sv]
// ============================================================================
// vn_sqrt
// Pipelined digit-by-digit square root of S * 2^32, one root bit per stage.
// ============================================================================
module vn_sqrt (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  vn_pkg::t_item         i_item,
    output vn_pkg::t_item         o_item,
    output logic [vn_pkg::LW-1:0] o_root
);
    import vn_pkg::*;

    t_item         r_item [LW];
    logic [LW-1:0] r_root [LW];
    logic [RW-1:0] r_rem  [LW];

    for (genvar j = 0; j < LW; j++) begin : g_stage
        localparam int K = LW - 1 - j;
        t_item           in_item;
        logic [LW-1:0]   in_root;
        logic [RW-1:0]   in_rem;
        logic [2*LW-1:0] rad;
        logic [RW-1:0]   cur;
        logic [RW-1:0]   trial;

        if (j == 0) begin : g_first
            assign in_item = i_item;
            assign in_root = '0;
            assign in_rem  = '0;
        end else begin : g_next
            assign in_item = r_item[j-1];
            assign in_root = r_root[j-1];
            assign in_rem  = r_rem[j-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rad   = {in_item.s, {SQ_PAD{1'b0}}};
        assign cur   = {in_rem[RW-3:0], rad[2*K+1 -: 2]};
        assign trial = RW'({in_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[j] <= in_item;
                if (cur >= trial) begin
                    r_rem[j]  <= cur - trial;
                    r_root[j] <= {in_root[LW-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= cur;
                    r_root[j] <= {in_root[LW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_item = r_item[LW-1];
    assign o_root = r_root[LW-1];

endmodule

[rtl/core/vn_div_lane.sv]
// ============================================================================
// vn_div_lane
// One divider lane: trunc(mag * 2^46 / len) in Q1.30, saturated and signed.
// ============================================================================
module vn_div_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [vn_pkg::CW-1:0]            i_mag,
    input  logic                             i_neg,
    input  logic [vn_pkg::LW-1:0]            i_len,
    output logic signed [vn_pkg::UNIT_W-1:0] o_unit
);
    import vn_pkg::*;

    logic [DW-1:0]  r_rem  [QW+1];
    logic [LW-1:0]  r_len  [QW+1];
    logic [QW-1:0]  r_q    [QW+1];
    logic           r_over [QW+1];
    logic           r_neg  [QW+1];
    logic [DW-1:0]  rem0;
    logic [QW:0]    q_sat;
    logic [UNIT_W-1:0] r_unit;

    // upper part of the numerator; reaching len means the quotient overflows
    assign rem0 = DW'({i_mag, {PRE_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= rem0;
            r_len[0]  <= i_len;
            r_q[0]    <= '0;
            r_over[0] <= (rem0 >= DW'(i_len));
            r_neg[0]  <= i_neg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= QW; j++) begin : g_stage
        logic [DW-1:0] sh;
        assign sh = {r_rem[j-1][DW-2:0], 1'b0};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[j]  <= r_len[j-1];
                r_over[j] <= r_over[j-1];
                r_neg[j]  <= r_neg[j-1];
                if (sh >= DW'(r_len[j-1])) begin
                    r_rem[j] <= sh - DW'(r_len[j-1]);
                    r_q[j]   <= {r_q[j-1][QW-2:0], 1'b1};
                end else begin
                    r_rem[j] <= sh;
                    r_q[j]   <= {r_q[j-1][QW-2:0], 1'b0};
                end
            end
        end
    end

    // saturate to one and apply the sign
    assign q_sat = (r_over[QW] || (r_q[QW] > UNIT_ONE)) ? {1'b0, UNIT_ONE}
                                                          : {1'b0, r_q[QW]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= r_neg[QW] ? (UNIT_W'(0) - UNIT_W'(q_sat)) : UNIT_W'(q_sat);
        end
    end

    assign o_unit = r_unit;

endmodule
